### hdl/bulk_array_frame_parser_core_assert.svh
// Assertion macros for the bulk array frame parser.
// Included by the top level; needs no package.
`ifndef BULK_ARRAY_FRAME_PARSER_CORE_ASSERT_SVH
`define BULK_ARRAY_FRAME_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define BAFP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bafp assertion failed");

// Next-cycle implication, disabled in reset.
`define BAFP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bafp assertion failed");

`endif

### hdl/bafp_pkg.sv
// Shared types and constants of the bulk array frame parser.
// No dependencies.
package bafp_pkg;

    localparam logic [3:0] PH_HUNT    = 4'd0;
    localparam logic [3:0] PH_CNT_NUM = 4'd1;
    localparam logic [3:0] PH_CNT_LF  = 4'd2;
    localparam logic [3:0] PH_DOLLAR  = 4'd3;
    localparam logic [3:0] PH_LEN_NUM = 4'd4;
    localparam logic [3:0] PH_LEN_LF  = 4'd5;
    localparam logic [3:0] PH_PAYLOAD = 4'd6;
    localparam logic [3:0] PH_PAY_CR  = 4'd7;
    localparam logic [3:0] PH_PAY_LF  = 4'd8;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_ONE    = 8'h31;
    localparam logic [7:0] CHAR_NINE   = 8'h39;

    typedef struct packed {
        logic [3:0] phase;
        logic [7:0] acc;
        logic [7:0] declared;
        logic [7:0] cur_field;
        logic [7:0] cur_length;
        logic [7:0] bytes_left;
    } parse_state_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic [7:0] field_index;
        logic [7:0] field_length;
        logic       first_in_field;
        logic       last_in_field;
        logic [7:0] field_total;
    } result_t;

endpackage

### hdl/bafp_step.sv
// One-byte parse step: next parser state and optional result.
// Depends on bafp_pkg.
module bafp_step #(
    parameter int unsigned MAX_FIELDS = 20
) (
    input  bafp_pkg::parse_state_t cur,
    input  logic [7:0]             in_byte,
    output bafp_pkg::parse_state_t nxt,
    output logic                   res_valid,
    output bafp_pkg::result_t      res
);
    import bafp_pkg::*;

    localparam logic [7:0] MAX_CNT = 8'(MAX_FIELDS);

    logic       err;
    logic       is_nz_digit;
    logic [7:0] acc_x10;
    logic [7:0] digit;
    logic [7:0] bl_dec;
    logic [7:0] field_inc;

    assign is_nz_digit = (in_byte >= CHAR_ONE) && (in_byte <= CHAR_NINE);
    assign acc_x10     = {cur.acc[4:0], 3'b000} + {cur.acc[6:0], 1'b0};
    assign digit       = in_byte - CHAR_ZERO;
    assign bl_dec      = (cur.bytes_left != 8'd0) ? cur.bytes_left - 8'd1 : cur.bytes_left;
    assign field_inc   = cur.cur_field + 8'd1;

    always_comb
    begin
        nxt       = cur;
        res_valid = 1'b0;
        res       = '0;
        err       = 1'b0;
        case (cur.phase)
            PH_CNT_NUM, PH_LEN_NUM:
            begin
                if (in_byte == CHAR_CR)
                begin
                    if (cur.acc == 8'd0)
                        err = 1'b1;
                    else if (cur.phase == PH_CNT_NUM)
                        nxt.phase = PH_CNT_LF;
                    else
                        nxt.phase = PH_LEN_LF;
                end
                else if (is_nz_digit)
                    nxt.acc = acc_x10 + digit;
                else if (in_byte == CHAR_ZERO && cur.acc != 8'd0)
                    nxt.acc = acc_x10;
                else
                    err = 1'b1;
            end
            PH_CNT_LF:
            begin
                if (in_byte != CHAR_LF || cur.acc > MAX_CNT)
                    err = 1'b1;
                else
                begin
                    nxt.declared  = cur.acc;
                    nxt.cur_field = 8'd0;
                    nxt.phase     = PH_DOLLAR;
                end
            end
            PH_DOLLAR:
            begin
                if (in_byte != CHAR_DOLLAR)
                    err = 1'b1;
                else
                begin
                    nxt.acc   = 8'd0;
                    nxt.phase = PH_LEN_NUM;
                end
            end
            PH_LEN_LF:
            begin
                if (in_byte != CHAR_LF)
                    err = 1'b1;
                else
                begin
                    nxt.cur_length = cur.acc;
                    nxt.bytes_left = cur.acc;
                    nxt.phase      = (cur.acc != 8'd0) ? PH_PAYLOAD : PH_PAY_CR;
                end
            end
            PH_PAYLOAD:
            begin
                res_valid          = 1'b1;
                res.kind           = KIND_DATA;
                res.data_byte      = in_byte;
                res.field_index    = cur.cur_field;
                res.field_length   = cur.cur_length;
                res.first_in_field = (cur.bytes_left == cur.cur_length);
                res.last_in_field  = (cur.bytes_left <= 8'd1);
                res.field_total    = cur.declared;
                nxt.bytes_left     = bl_dec;
                if (bl_dec == 8'd0)
                    nxt.phase = PH_PAY_CR;
            end
            PH_PAY_CR:
            begin
                if (in_byte != CHAR_CR)
                    err = 1'b1;
                else
                    nxt.phase = PH_PAY_LF;
            end
            PH_PAY_LF:
            begin
                if (in_byte != CHAR_LF)
                    err = 1'b1;
                else if (field_inc >= cur.declared)
                begin
                    res_valid       = 1'b1;
                    res.kind        = KIND_DONE;
                    res.field_total = cur.declared;
                    nxt.phase       = PH_HUNT;
                    nxt.acc         = 8'd0;
                    nxt.cur_field   = 8'd0;
                    nxt.cur_length  = 8'd0;
                    nxt.bytes_left  = 8'd0;
                end
                else
                begin
                    nxt.cur_field = field_inc;
                    nxt.phase     = PH_DOLLAR;
                end
            end
            default:
            begin
                nxt.phase = PH_HUNT;
                if (in_byte == CHAR_STAR)
                begin
                    nxt       = '0;
                    nxt.phase = PH_CNT_NUM;
                end
            end
        endcase
        if (err)
        begin
            res_valid       = 1'b1;
            res             = '0;
            res.kind        = KIND_ERR;
            res.field_total = cur.declared;
            nxt.phase       = PH_HUNT;
            nxt.acc         = 8'd0;
            nxt.cur_field   = 8'd0;
            nxt.cur_length  = 8'd0;
            nxt.bytes_left  = 8'd0;
        end
    end

endmodule

### hdl/bafp_outq.sv
// Result register with one skid entry; stall to the source is registered.
// Depends on bafp_pkg.
module bafp_outq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  bafp_pkg::result_t push_res,
    input  logic              down_stall,
    output logic              out_valid,
    output bafp_pkg::result_t out_res,
    output logic              full
);
    import bafp_pkg::*;

    logic    out_valid_reg;
    logic    out_valid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t out_res_reg;
    result_t out_res_next;
    result_t skid_res_reg;
    result_t skid_res_next;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_res_next    = out_res_reg;
        skid_valid_next = skid_valid_reg;
        skid_res_next   = skid_res_reg;
        if (!out_valid_reg || !down_stall)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_res_next    = skid_res_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                out_res_next   = push_res;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_res_next   = push_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg  <= out_res_next;
        skid_res_reg <= skid_res_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;
    assign full      = skid_valid_reg;

endmodule

### hdl/bulk_array_frame_parser_core.sv
// Bulk array frame parser: byte-serial recognizer of '*' count / '$' length frames.
// A result is registered at the edge that accepts its byte, in the result register or, if that stalls, the skid.
// Throughput: one byte per cycle while item_stall is low, set by the combinational parse step and state register.
// A one-entry skid behind the result register keeps item_stall registered.
// Reset (rst_n, async, active low): hunting for '*', all counters zero, no result held.
// Depends on bafp_pkg, bafp_step, bafp_outq and the assertion macro header.
`include "bulk_array_frame_parser_core_assert.svh"

module bulk_array_frame_parser_core #(
    parameter int unsigned MAX_FIELDS = 20
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  logic [7:0] in_byte,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [1:0] kind,
    output logic [7:0] data_byte,
    output logic [7:0] field_index,
    output logic [7:0] field_length,
    output logic       first_in_field,
    output logic       last_in_field,
    output logic [7:0] field_total
);
    import bafp_pkg::*;

    localparam logic [7:0] MAX_CNT = 8'(MAX_FIELDS);

    parse_state_t state_reg;
    parse_state_t state_next;
    parse_state_t step_state;
    logic         step_valid;
    result_t      step_res;
    result_t      out_res;
    logic         accept;

    assign accept = item_valid && !item_stall;

    bafp_step #(
        .MAX_FIELDS (MAX_FIELDS)
    ) u_step (
        .cur       (state_reg),
        .in_byte   (in_byte),
        .nxt       (step_state),
        .res_valid (step_valid),
        .res       (step_res)
    );

    assign state_next = accept ? step_state : state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{PH_HUNT, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    bafp_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept && step_valid),
        .push_res   (step_res),
        .down_stall (result_stall),
        .out_valid  (result_valid),
        .out_res    (out_res),
        .full       (item_stall)
    );

    assign kind           = out_res.kind;
    assign data_byte      = out_res.data_byte;
    assign field_index    = out_res.field_index;
    assign field_length   = out_res.field_length;
    assign first_in_field = out_res.first_in_field;
    assign last_in_field  = out_res.last_in_field;
    assign field_total    = out_res.field_total;

    `BAFP_ASSERT_IMP(a_skid_needs_out, clk, rst_n, item_stall, result_valid)
    `BAFP_ASSERT_NXT(a_skid_drains, clk, rst_n, item_stall && !result_stall, result_valid && !item_stall)
    `BAFP_ASSERT_IMP(a_data_index_range, clk, rst_n, result_valid && kind == KIND_DATA, field_index < field_total)
    `BAFP_ASSERT_IMP(a_payload_nonempty, clk, rst_n, state_reg.phase == PH_PAYLOAD, state_reg.bytes_left != 8'd0)
    `BAFP_ASSERT_IMP(a_count_bounded, clk, rst_n, 1'b1, state_reg.declared <= MAX_CNT)

endmodule

### sim/tb_bulk_array_frame_parser_core.sv
`timescale 1ns / 100ps
// Testbench for bulk_array_frame_parser_core: byte streams of array frames, broken and whole.
// An in-bench parser predicts every result; depends on bafp_pkg and the core RTL.
module tb_bulk_array_frame_parser_core;
    import bafp_pkg::*;

    localparam int unsigned MAX_FIELDS = 20;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       item_valid = 1'b0;
    logic       item_stall;
    logic [7:0] in_byte = 8'h00;
    logic       result_valid;
    logic       result_stall = 1'b0;
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [7:0] field_index;
    logic [7:0] field_length;
    logic       first_in_field;
    logic       last_in_field;
    logic [7:0] field_total;

    logic [7:0]  tx_stream[$];
    logic [7:0]  frame_buf[$];
    result_t     events_due[$];
    parse_state_t pst;
    int unsigned mismatch_count = 0;
    int unsigned tx_idle_pct = 0;
    int unsigned rx_stall_pct = 0;
    logic        tx_hold = 1'b0;
    logic        rx_hold_kick = 1'b0;
    logic        rx_hold_seen = 1'b0;
    int unsigned rx_hold_left = 0;

    bulk_array_frame_parser_core #(.MAX_FIELDS(MAX_FIELDS)) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .in_byte(in_byte),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .kind(kind),
        .data_byte(data_byte),
        .field_index(field_index),
        .field_length(field_length),
        .first_in_field(first_in_field),
        .last_in_field(last_in_field),
        .field_total(field_total)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // completion or error: both close the frame and go back to the hunt
    function automatic void post_status(input logic [1:0] code);
        result_t ev;
        ev = '0;
        ev.kind = code;
        ev.field_total = pst.declared;
        events_due.push_back(ev);
        pst.phase = PH_HUNT;
        pst.acc = '0;
        pst.cur_field = '0;
        pst.cur_length = '0;
        pst.bytes_left = '0;
    endfunction

    function automatic void parse_byte(input logic [7:0] b);
        result_t ev;
        case (pst.phase)
            PH_CNT_NUM, PH_LEN_NUM:
                if (b == CHAR_CR)
                begin
                    if (pst.acc == 8'd0)
                        post_status(KIND_ERR);
                    else
                        pst.phase = (pst.phase == PH_CNT_NUM) ? PH_CNT_LF : PH_LEN_LF;
                end
                else if (b >= CHAR_ONE && b <= CHAR_NINE)
                    pst.acc = 8'(pst.acc * 10 + (b - CHAR_ZERO));
                else if (b == CHAR_ZERO && pst.acc != 8'd0)
                    pst.acc = 8'(pst.acc * 10);
                else
                    post_status(KIND_ERR);
            PH_CNT_LF:
                if (b != CHAR_LF || pst.acc > MAX_FIELDS)
                    post_status(KIND_ERR);
                else
                begin
                    pst.declared = pst.acc;
                    pst.cur_field = '0;
                    pst.phase = PH_DOLLAR;
                end
            PH_DOLLAR:
                if (b != CHAR_DOLLAR)
                    post_status(KIND_ERR);
                else
                begin
                    pst.acc = '0;
                    pst.phase = PH_LEN_NUM;
                end
            PH_LEN_LF:
                if (b != CHAR_LF)
                    post_status(KIND_ERR);
                else
                begin
                    pst.cur_length = pst.acc;
                    pst.bytes_left = pst.acc;
                    pst.phase = (pst.acc != 8'd0) ? PH_PAYLOAD : PH_PAY_CR;
                end
            PH_PAYLOAD:
            begin
                ev = '0;
                ev.kind = KIND_DATA;
                ev.data_byte = b;
                ev.field_index = pst.cur_field;
                ev.field_length = pst.cur_length;
                ev.first_in_field = (pst.bytes_left == pst.cur_length);
                ev.last_in_field = (pst.bytes_left <= 8'd1);
                ev.field_total = pst.declared;
                events_due.push_back(ev);
                if (pst.bytes_left != 8'd0)
                    pst.bytes_left = pst.bytes_left - 8'd1;
                if (pst.bytes_left == 8'd0)
                    pst.phase = PH_PAY_CR;
            end
            PH_PAY_CR:
                if (b != CHAR_CR)
                    post_status(KIND_ERR);
                else
                    pst.phase = PH_PAY_LF;
            PH_PAY_LF:
                if (b != CHAR_LF)
                    post_status(KIND_ERR);
                else
                begin
                    pst.cur_field = pst.cur_field + 8'd1;
                    if (pst.cur_field >= pst.declared)
                        post_status(KIND_DONE);
                    else
                        pst.phase = PH_DOLLAR;
                end
            default:
            begin
                pst.phase = PH_HUNT;
                if (b == CHAR_STAR)
                begin
                    pst.acc = '0;
                    pst.declared = '0;
                    pst.cur_field = '0;
                    pst.cur_length = '0;
                    pst.bytes_left = '0;
                    pst.phase = PH_CNT_NUM;
                end
            end
        endcase
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        $display("ERROR %0t: %s", $time, msg);
    endtask

    task automatic check_result();
        result_t got;
        result_t want;
        string   bad;
        got = {kind, data_byte, field_index, field_length, first_in_field, last_in_field,
               field_total};
        if (events_due.size() == 0)
        begin
            flag_mismatch($sformatf("result %h with nothing due", got));
            return;
        end
        want = events_due.pop_front();
        bad = "";
        if (got.kind !== want.kind) bad = {bad, " kind"};
        if (got.data_byte !== want.data_byte) bad = {bad, " data_byte"};
        if (got.field_index !== want.field_index) bad = {bad, " field_index"};
        if (got.field_length !== want.field_length) bad = {bad, " field_length"};
        if (got.first_in_field !== want.first_in_field) bad = {bad, " first_in_field"};
        if (got.last_in_field !== want.last_in_field) bad = {bad, " last_in_field"};
        if (got.field_total !== want.field_total) bad = {bad, " field_total"};
        if (bad != "")
            flag_mismatch($sformatf("wrong%s: got %h, want %h", bad, got, want));
    endtask

    // sender
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            in_byte <= 8'h00;
            pst = '0;
            pst.phase = PH_HUNT;
        end
        else
        begin
            if (item_valid && !item_stall)
                parse_byte(in_byte);
            if (!item_valid || !item_stall)
            begin
                if (tx_stream.size() != 0 && !tx_hold && $urandom_range(99) >= tx_idle_pct)
                begin
                    item_valid <= 1'b1;
                    in_byte <= tx_stream.pop_front();
                end
                else
                begin
                    item_valid <= 1'b0;
                    in_byte <= 8'($urandom);
                end
            end
        end
    end

    // receiver
    always @(posedge clk)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
                check_result();
            result_stall <= (rx_hold_left != 0) || ($urandom_range(99) < rx_stall_pct);
        end
    end

    // long receiver hold-off, started by a toggle of rx_hold_kick
    always @(posedge clk)
    begin
        if (rx_hold_kick != rx_hold_seen)
        begin
            rx_hold_seen <= rx_hold_kick;
            rx_hold_left <= 400;
        end
        else if (rx_hold_left != 0)
            rx_hold_left <= rx_hold_left - 1;
    end

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            frame_buf.push_back(s[i]);
    endtask

    task automatic put_number(input int unsigned v);
        put_text($sformatf("%0d", v));
    endtask

    // arbitrary digits: leading zeros, wraps past 255, wraps to zero
    task automatic put_digit_run();
        repeat ($urandom_range(1, 4))
            frame_buf.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
    endtask

    task automatic put_crlf();
        frame_buf.push_back(CHAR_CR);
        frame_buf.push_back(CHAR_LF);
    endtask

    task automatic commit_frame();
        foreach (frame_buf[i])
            tx_stream.push_back(frame_buf[i]);
        frame_buf.delete();
    endtask

    task automatic queue_traffic(input int unsigned budget);
        int unsigned sent;
        int unsigned r;
        int unsigned cnt;
        int unsigned nfld;
        int unsigned len;
        int unsigned pos;
        sent = 0;
        while (sent < budget)
        begin
            r = $urandom_range(99);
            if (r < 6)
            begin
                repeat ($urandom_range(1, 6))
                    tx_stream.push_back(8'($urandom));
                continue;
            end
            frame_buf.push_back(CHAR_STAR);
            r = $urandom_range(99);
            if (r < 70)
                cnt = $urandom_range(1, 3);
            else if (r < 80)
                cnt = $urandom_range(4, MAX_FIELDS - 1);
            else if (r < 86)
                cnt = MAX_FIELDS;
            else
                cnt = $urandom_range(MAX_FIELDS + 1, 255);
            nfld = cnt;
            if (r >= 93)
            begin
                put_digit_run();
                nfld = $urandom_range(1, 3);
            end
            else
            begin
                put_number(cnt);
                if (cnt > MAX_FIELDS)
                    nfld = $urandom_range(0, 1);
            end
            put_crlf();
            repeat (nfld)
            begin
                frame_buf.push_back(CHAR_DOLLAR);
                r = $urandom_range(99);
                if (r < 85)
                    len = $urandom_range(1, 6);
                else if (r < 95)
                    len = $urandom_range(7, 64);
                else if (r < 96)
                    len = 255;
                else
                    len = 0;
                if (len == 0)
                begin
                    put_digit_run();
                    len = $urandom_range(1, 6);
                end
                else
                    put_number(len);
                put_crlf();
                repeat (len)
                    frame_buf.push_back(8'($urandom));
                put_crlf();
            end
            r = $urandom_range(99);
            pos = $urandom_range(1, frame_buf.size() - 1);
            if (r < 10)
            begin
                case ($urandom_range(0, 5))
                    0: frame_buf[pos] = CHAR_STAR;
                    1: frame_buf[pos] = CHAR_DOLLAR;
                    2: frame_buf[pos] = CHAR_CR;
                    3: frame_buf[pos] = CHAR_LF;
                    4: frame_buf[pos] = CHAR_ZERO;
                    default: frame_buf[pos] = 8'($urandom);
                endcase
            end
            else if (r < 14)
            begin
                while (frame_buf.size() > pos)
                    void'(frame_buf.pop_back());
            end
            sent += frame_buf.size();
            commit_frame();
        end
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (tx_stream.size() != 0 || item_valid || events_due.size() != 0);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        tx_idle_pct <= 16;
        rx_stall_pct <= 88;
        @(negedge clk);

        // payload extremes, then leading zero, empty count, count too large,
        // and a misplaced star that is an error and does not start a new frame
        put_text("*1");
        put_crlf();
        put_text("$2");
        put_crlf();
        frame_buf.push_back(8'h00);
        frame_buf.push_back(8'hFF);
        put_crlf();
        put_text("*0");
        put_text("*");
        frame_buf.push_back(CHAR_CR);
        put_text("*");
        put_number(MAX_FIELDS + 1);
        put_crlf();
        put_text("**1");
        put_crlf();
        commit_frame();
        queue_traffic(640);
        wait_idle();

        @(posedge clk);
        tx_idle_pct <= 88;
        rx_stall_pct <= 16;
        @(negedge clk);
        queue_traffic(640);
        while (tx_stream.size() > 300)
            @(negedge clk);
        @(posedge clk);
        tx_hold <= 1'b1;
        do
            @(negedge clk);
        while (item_valid || events_due.size() != 0);
        @(posedge clk);
        tx_hold <= 1'b0;
        wait_idle();

        // back-to-back traffic into a long receiver hold-off
        @(posedge clk);
        tx_idle_pct <= 0;
        rx_stall_pct <= 0;
        rx_hold_kick <= ~rx_hold_kick;
        @(negedge clk);
        put_text("*1");
        put_crlf();
        put_text("$200");
        put_crlf();
        repeat (200)
            frame_buf.push_back(8'($urandom));
        put_crlf();
        commit_frame();
        queue_traffic(420);
        wait_idle();

        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("ERROR: timeout");
        $display("FAILED: results differ");
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/bafp_pkg.sv
hdl/bafp_step.sv
hdl/bafp_outq.sv
hdl/bulk_array_frame_parser_core.sv
sim/tb_bulk_array_frame_parser_core.sv
